// ===== hw/rtl/wsg_pkg.sv =====
// ----------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the wavetable sample generator
// Waveform codes, arithmetic constants, the quarter-wave sine table and the
// structs that pass between controller, datapath and register block.
// ----------------------------------------------------------------------------
package wsg_pkg;

    // fixed field widths
    localparam int IDX_W    = 8;
    localparam int SAMPLE_W = 8;
    localparam int PERIOD_W = 16;
    localparam int MODE_W   = 3;
    localparam int FREQ_W   = 16;
    localparam int DIVR_W   = 15;   // clamped frequency fits in 15 bits
    localparam int REM_W    = 16;   // shifted remainder stays below 2 * 20000
    localparam int SEED_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int CYCLE_LENGTH         = 256;
    localparam int MASTER_CLOCK_DEFAULT = 3546895;

    // waveform codes
    localparam logic [MODE_W-1:0] MODE_SINE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAW    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NOISE  = 3'd3;

    // register indexes
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_FREQ = 1'b1;

    // reset values
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_SINE;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd440;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd12345;

    // linear congruential generator
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

    // clamps
    localparam logic [FREQ_W-1:0]   FREQ_MIN   = 16'd20;
    localparam logic [FREQ_W-1:0]   FREQ_MAX   = 16'd20000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd124;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'd65535;

    localparam logic [SAMPLE_W-1:0] SQUARE_HIGH = 8'sd127;
    localparam logic [SAMPLE_W-1:0] SQUARE_LOW  = -8'sd127;
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP   = 8'h80;
    localparam logic [7:0]          SAW_SCALE   = 8'd255;

    // sine positions 0..64, the rest of the cycle follows by symmetry
    localparam logic [6:0] SINE_QUARTER [0:64] = '{
          7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd15,  7'd18,  7'd21,
         7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
         7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
         7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
         7'd89,  7'd91,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd103,
        7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
        7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
        7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
        7'd127
    };

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FREQ_W-1:0] freq;
    } cfg_t;

    typedef struct packed {
        logic load;      // capture item, start division
        logic step;      // one quotient bit
        logic publish;   // move result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

// ===== hw/rtl/wsg_if.sv =====
// ----------------------------------------------------------------------------
// wsg_if: valid/ready channels of the wavetable sample generator
// Index channel towards the block, sample channel away from it.
// ----------------------------------------------------------------------------
interface wsg_index_if;
    logic                       valid;
    logic                       ready;
    logic [wsg_pkg::IDX_W-1:0]  sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

interface wsg_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsg_pkg::SAMPLE_W-1:0] sample_value;
    logic [wsg_pkg::PERIOD_W-1:0]        playback_period;

    modport source (output valid, output sample_value, output playback_period, input ready);
    modport sink   (input valid, input sample_value, input playback_period, output ready);
endinterface

// ===== hw/rtl/wsg_regs.sv =====
// ----------------------------------------------------------------------------
// wsg_regs: configuration registers
// APB-style write/read of waveform mode and tone frequency.
// ----------------------------------------------------------------------------
module wsg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsg_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsg_pkg::DATA_W-1:0]    pwdata,
    output logic [wsg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output wsg_pkg::cfg_t                 cfg
);

    logic [wsg_pkg::MODE_W-1:0] mode_reg;
    logic [wsg_pkg::FREQ_W-1:0] freq_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes, word-select on address bit 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= wsg_pkg::MODE_RESET;
            freq_reg <= wsg_pkg::FREQ_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                wsg_pkg::REG_MODE: mode_reg <= pwdata[wsg_pkg::MODE_W-1:0];
                wsg_pkg::REG_FREQ: freq_reg <= pwdata[wsg_pkg::FREQ_W-1:0];
                default:           mode_reg <= mode_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            wsg_pkg::REG_MODE: prdata = {{(wsg_pkg::DATA_W-wsg_pkg::MODE_W){1'b0}}, mode_reg};
            wsg_pkg::REG_FREQ: prdata = {{(wsg_pkg::DATA_W-wsg_pkg::FREQ_W){1'b0}}, freq_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.mode = mode_reg;
    assign cfg.freq = freq_reg;

endmodule

// ===== hw/rtl/wsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsg_ctrl: sequencing of one item
// Accepts an index, runs the period divider bit by bit, hands the result on.
// ----------------------------------------------------------------------------
module wsg_ctrl #(
    parameter int MASTER_CLOCK = wsg_pkg::MASTER_CLOCK_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  wsg_pkg::dp_status_t    status,
    output wsg_pkg::ctrl_cmd_t     cmd
);

    localparam int DEND_W = $clog2(MASTER_CLOCK / wsg_pkg::CYCLE_LENGTH + 1);
    localparam int CNT_W  = (DEND_W > 1) ? $clog2(DEND_W) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(DEND_W - 1));

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/wsg_dpath.sv =====
// ----------------------------------------------------------------------------
// wsg_dpath: sample and period datapath
// Waveform lookup, noise generator, restoring period divider, output register.
// ----------------------------------------------------------------------------
module wsg_dpath #(
    parameter int MASTER_CLOCK = wsg_pkg::MASTER_CLOCK_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wsg_pkg::cfg_t                        cfg,
    input  wsg_pkg::ctrl_cmd_t                   cmd,
    output wsg_pkg::dp_status_t                  status,
    input  logic [wsg_pkg::IDX_W-1:0]            sample_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wsg_pkg::SAMPLE_W-1:0]  sample_value,
    output logic [wsg_pkg::PERIOD_W-1:0]         playback_period
);

    // dividend is the master clock over the cycle length, a constant
    localparam int DEND_W = $clog2(MASTER_CLOCK / wsg_pkg::CYCLE_LENGTH + 1);
    localparam int CMP_W  = (DEND_W > wsg_pkg::PERIOD_W) ? DEND_W : wsg_pkg::PERIOD_W;
    localparam logic [DEND_W-1:0] DIVIDEND = DEND_W'(MASTER_CLOCK / wsg_pkg::CYCLE_LENGTH);

    logic [wsg_pkg::SEED_W-1:0]   seed_reg;
    logic [wsg_pkg::SEED_W-1:0]   seed_step;
    logic [wsg_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic [wsg_pkg::DIVR_W-1:0]   divr_reg, divr_next;
    logic [wsg_pkg::REM_W-1:0]    rem_reg;
    logic [DEND_W-1:0]            quo_reg;
    logic [wsg_pkg::REM_W-1:0]    trial;
    logic                         trial_ge;
    logic [CMP_W-1:0]             quo_ext;
    logic [wsg_pkg::PERIOD_W-1:0] period_clamped;
    logic                         out_valid_reg;
    logic signed [wsg_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [wsg_pkg::PERIOD_W-1:0]        out_period_reg;

    logic [6:0]  sine_pos;
    logic [7:0]  sine_mirror;
    logic [6:0]  sine_q;
    logic [7:0]  sine_mag;
    logic [15:0] saw_prod;

    // noise generator step
    assign seed_step = wsg_pkg::SEED_W'(seed_reg * wsg_pkg::LCG_MUL + wsg_pkg::LCG_ADD);

    // sine by quarter-wave symmetry
    assign sine_pos    = sample_index[6:0];
    assign sine_mirror = 8'd128 - {1'b0, sine_pos};
    assign sine_q      = (sine_pos > 7'd64) ? sine_mirror[6:0] : sine_pos;
    assign sine_mag    = {1'b0, wsg_pkg::SINE_QUARTER[sine_q]};

    assign saw_prod = 16'(sample_index * wsg_pkg::SAW_SCALE);

    // waveform select; subtracting 128 from an 8-bit value flips its top bit
    always_comb
    begin
        unique case (cfg.mode)
            wsg_pkg::MODE_SQUARE:
                sample_next = sample_index[7] ? wsg_pkg::SQUARE_LOW : wsg_pkg::SQUARE_HIGH;
            wsg_pkg::MODE_SAW:
                sample_next = saw_prod[15:8] ^ wsg_pkg::SIGN_FLIP;
            wsg_pkg::MODE_NOISE:
                sample_next = seed_step[23:16] ^ wsg_pkg::SIGN_FLIP;
            default:
                sample_next = sample_index[7] ? 8'(8'd0 - sine_mag) : sine_mag;
        endcase
    end

    // frequency clamp, becomes the divisor
    always_comb
    begin
        priority if (cfg.freq < wsg_pkg::FREQ_MIN)
            divr_next = wsg_pkg::DIVR_W'(wsg_pkg::FREQ_MIN);
        else if (cfg.freq > wsg_pkg::FREQ_MAX)
            divr_next = wsg_pkg::DIVR_W'(wsg_pkg::FREQ_MAX);
        else
            divr_next = cfg.freq[wsg_pkg::DIVR_W-1:0];
    end

    // noise state moves only on noise items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= wsg_pkg::SEED_RESET;
        end
        else if (cmd.load && (cfg.mode == wsg_pkg::MODE_NOISE))
        begin
            seed_reg <= seed_step;
        end
    end

    // restoring divider, one quotient bit per step
    assign trial    = {rem_reg[wsg_pkg::REM_W-2:0], quo_reg[DEND_W-1]};
    assign trial_ge = (trial >= {1'b0, divr_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_next;
            divr_reg   <= divr_next;
            rem_reg    <= '0;
            quo_reg    <= DIVIDEND;
        end
        else if (cmd.step)
        begin
            rem_reg <= trial_ge ? (trial - {1'b0, divr_reg}) : trial;
            quo_reg <= {quo_reg[DEND_W-2:0], trial_ge};
        end
    end

    // period clamp
    assign quo_ext = CMP_W'(quo_reg);

    always_comb
    begin
        priority if (quo_ext < CMP_W'(wsg_pkg::PERIOD_MIN))
            period_clamped = wsg_pkg::PERIOD_MIN;
        else if (quo_ext > CMP_W'(wsg_pkg::PERIOD_MAX))
            period_clamped = wsg_pkg::PERIOD_MAX;
        else
            period_clamped = quo_ext[wsg_pkg::PERIOD_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_sample_reg <= sample_reg;
            out_period_reg <= period_clamped;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_value    = out_sample_reg;
    assign playback_period = out_period_reg;

endmodule

// ===== hw/rtl/wavetable_sample_generator_unit.sv =====
// ----------------------------------------------------------------------------
// wavetable_sample_generator_unit: wavetable oscillator with noise source
// Sine, square, sawtooth or noise sample per index, with playback period.
// ----------------------------------------------------------------------------
// Sequence: the index beat loads the item, the bit-serial period divider finds
// one quotient bit per step for N = bits of MASTER_CLOCK/256 (14 at the
// default clock), and the result moves into the output register. A new index
// is taken only after the previous item is published; a finished sample waits in the output register until taken.
// Reset (rst_n, asynchronous): mode sine, frequency 440, noise seed 12345.
module wavetable_sample_generator_unit #(
    parameter int MASTER_CLOCK = wsg_pkg::MASTER_CLOCK_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wsg_pkg::ADDR_W-1:0]  paddr,
    input  logic [wsg_pkg::DATA_W-1:0]  pwdata,
    output logic [wsg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    wsg_index_if.sink                   sample_in,
    wsg_sample_if.source                sample_out
);

    wsg_pkg::cfg_t       cfg;
    wsg_pkg::ctrl_cmd_t  cmd;
    wsg_pkg::dp_status_t status;

    wsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsg_ctrl #(
        .MASTER_CLOCK (MASTER_CLOCK)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    wsg_dpath #(
        .MASTER_CLOCK (MASTER_CLOCK)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .sample_index    (sample_in.sample_index),
        .out_valid       (sample_out.valid),
        .out_ready       (sample_out.ready),
        .sample_value    (sample_out.sample_value),
        .playback_period (sample_out.playback_period)
    );

endmodule

// ===== hw/rtl/wsg_checker.sv =====
// ----------------------------------------------------------------------------
// wsg_checker: port-level assertions of the sample generator
// Output beat stability, period range and one-item-at-a-time acceptance.
// ----------------------------------------------------------------------------
module wsg_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [wsg_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic [wsg_pkg::PERIOD_W-1:0]         playback_period
);

    // a stalled sample beat stays up with its payload unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(sample_value) && $stable(playback_period))
        else $error("sample beat dropped or changed while stalled");

    // the period never falls below its clamp minimum
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> playback_period >= wsg_pkg::PERIOD_MIN)
        else $error("playback period below minimum");

    // after an index beat the block is busy dividing
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("index accepted while previous item in progress");

    // a result only appears after the divider has run
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
        else $error("sample beat appeared straight after an index beat");

endmodule

bind wavetable_sample_generator_unit wsg_checker u_wsg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample_in.valid),
    .in_ready        (sample_in.ready),
    .out_valid       (sample_out.valid),
    .out_ready       (sample_out.ready),
    .sample_value    (sample_out.sample_value),
    .playback_period (sample_out.playback_period)
);
